>>> sv/sfcmc_pkg.sv
// shared constants, codes and types of the contact-material cache
package sfcmc_pkg;

    localparam int DEF_SHARDS  = 16;
    localparam int DEF_ENTRIES = 64;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 16;
    localparam int FUNC_W = 2;

    // operation codes; the fourth code means nothing
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_PERSIST = 2'd1,
        FUNC_REMOVE  = 2'd2
    } t_func;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_BASE,
        ST_SEARCH,
        ST_HIT,
        ST_VREAD,
        ST_INSERT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic             settings_valid;
        logic             cache_hit;
        logic [VAL_W-1:0] friction;
        logic [VAL_W-1:0] restitution;
    } t_result;

endpackage

>>> sv/sfcmc_if.sv
// valid/ready channel interfaces for contact items and result items
interface sfcmc_in_if
    import sfcmc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  contact_key;
    logic              terrain_layer_involved;
    logic              terrain_material_seen;
    logic [VAL_W-1:0]  friction_a;
    logic [VAL_W-1:0]  restitution_a;
    logic [VAL_W-1:0]  friction_b;
    logic [VAL_W-1:0]  restitution_b;

    modport source (
        output valid, func, contact_key, terrain_layer_involved, terrain_material_seen,
               friction_a, restitution_a, friction_b, restitution_b,
        input  ready
    );
    modport sink (
        input  valid, func, contact_key, terrain_layer_involved, terrain_material_seen,
               friction_a, restitution_a, friction_b, restitution_b,
        output ready
    );
endinterface

interface sfcmc_out_if
    import sfcmc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             settings_valid;
    logic             cache_hit;
    logic [VAL_W-1:0] friction_out;
    logic [VAL_W-1:0] restitution_out;

    modport source (
        output valid, settings_valid, cache_hit, friction_out, restitution_out,
        input  ready
    );
    modport sink (
        input  valid, settings_valid, cache_hit, friction_out, restitution_out,
        output ready
    );
endinterface

>>> sv/sharded_fifo_contact_material_cache.sv
// top level of the sharded contact-material cache
//
// Contact-material cache, one item at a time. A contact key picks its shard as
// key modulo SHARDS; the shard's ENTRIES slots are scanned from slot 0 for the
// first equal key (key 0 is empty and never hits). With the terrain layer flag
// set, add or persist hits return the stored friction and restitution, and an
// add miss with a terrain material returns sqrt(fa*fb) and max(ra,rb) and
// writes them at the shard's FIFO pointer; remove clears the matching key.
// After reset a clearing pass empties the key memory and the insert pointers,
// one slot at a time; no item is taken meanwhile. Each item then goes through
// the key reduction (folded sum of 16-bit key chunks, reciprocal multiply,
// remainder), the shard base, the scan (one key memory read a cycle through
// its single read port), a fetch of stored values or an insert, and the
// hand-over of the result to the output register; the next input is taken
// only after that hand-over. The square root (16 steps) runs alongside the
// key reduction and the scan; an add of the empty key skips the scan and
// waits for it in the insert step. A finished result waits in the output
// register while the next item is taken; a result that cannot leave the
// output register holds the block.
module sharded_fifo_contact_material_cache
    import sfcmc_pkg::*;
#(
    parameter int SHARDS  = DEF_SHARDS,
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfcmc_in_if.sink     i_in,
    sfcmc_out_if.source  o_out
);
    localparam int SLOTS    = SHARDS * ENTRIES;
    localparam int SLOT_AW  = $clog2(SLOTS);
    localparam int SHARD_AW = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam int PTR_W    = $clog2(ENTRIES);

    // control
    t_state              r_state, n_state;
    logic [SLOT_AW-1:0]  r_clr, n_clr;
    logic                r_out_v, n_out_v;
    logic                r_rd_done, n_rd_done;
    logic                r_chk_v, n_chk_v;

    // item held while it is worked on
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [KEY_W-1:0]    r_key, n_key;
    logic                r_layer, n_layer;
    logic                r_terrain, n_terrain;
    logic [VAL_W-1:0]    r_ra, n_ra;
    logic [VAL_W-1:0]    r_rb, n_rb;

    // scan bookkeeping
    logic [SHARD_AW-1:0] r_shard, n_shard;
    logic [SLOT_AW-1:0]  r_base, n_base;
    logic [PTR_W-1:0]    r_rd_idx, n_rd_idx;
    logic [PTR_W-1:0]    r_chk_idx, n_chk_idx;
    logic [SLOT_AW-1:0]  r_slot, n_slot;

    t_result             r_res, n_res;
    t_result             r_out, n_out;

    // memory ports
    logic                key_we;
    logic [SLOT_AW-1:0]  key_waddr;
    logic [KEY_W-1:0]    key_wdata;
    logic [SLOT_AW-1:0]  key_raddr;
    logic [KEY_W-1:0]    key_rdata;
    logic                val_we;
    logic [SLOT_AW-1:0]  val_waddr;
    logic [2*VAL_W-1:0]  val_wdata;
    logic [2*VAL_W-1:0]  val_rdata;
    logic                ptr_we;
    logic [SHARD_AW-1:0] ptr_waddr;
    logic [PTR_W-1:0]    ptr_wdata;
    logic [PTR_W-1:0]    ptr_rdata;

    logic                in_ready;
    logic                in_xfer;
    logic                mod_done;
    logic [SHARD_AW-1:0] mod_rem;
    logic                sqrt_done;
    logic [VAL_W-1:0]    sqrt_root;
    logic [VAL_W-1:0]    max_r;
    logic [PTR_W-1:0]    ptr_next;
    logic                key_zero;
    logic                add_terrain;

    assign in_ready    = (r_state == ST_IDLE);
    assign in_xfer     = i_in.valid && in_ready;
    assign key_zero    = (r_key == '0);
    assign add_terrain = (r_func == FUNC_ADD) && r_terrain;
    assign max_r       = (r_ra > r_rb) ? r_ra : r_rb;
    assign ptr_next    = (ptr_rdata == PTR_W'(ENTRIES - 1)) ? '0 : ptr_rdata + 1'b1;

    // the scan address runs ahead of the compare through the registered read
    assign key_raddr = r_base + SLOT_AW'(r_rd_idx);

    sfcmc_keymod #(.SHARDS(SHARDS)) u_keymod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_key   (i_in.contact_key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    sfcmc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_a     (i_in.friction_a),
        .i_b     (i_in.friction_b),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    sfcmc_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // friction in the upper half, restitution in the lower half
    sfcmc_ram #(.WIDTH(2 * VAL_W), .DEPTH(SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (r_slot),
        .o_rdata (val_rdata)
    );

    // insert pointer per shard, read at the current shard all the time
    sfcmc_ram #(.WIDTH(PTR_W), .DEPTH(SHARDS)) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (ptr_waddr),
        .i_wdata (ptr_wdata),
        .i_raddr (r_shard),
        .o_rdata (ptr_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_rd_done = r_rd_done;
        n_chk_v   = r_chk_v;
        n_func    = r_func;
        n_key     = r_key;
        n_layer   = r_layer;
        n_terrain = r_terrain;
        n_ra      = r_ra;
        n_rb      = r_rb;
        n_shard   = r_shard;
        n_base    = r_base;
        n_rd_idx  = r_rd_idx;
        n_chk_idx = r_chk_idx;
        n_slot    = r_slot;
        n_res     = r_res;
        n_out     = r_out;
        // output register drains on its transfer
        n_out_v   = r_out_v && !o_out.ready;

        key_we    = 1'b0;
        key_waddr = r_slot;
        key_wdata = '0;
        val_we    = 1'b0;
        val_waddr = r_base + SLOT_AW'(ptr_rdata);
        val_wdata = {sqrt_root, max_r};
        ptr_we    = 1'b0;
        ptr_waddr = r_shard;
        ptr_wdata = ptr_next;

        unique case (r_state)
            ST_CLEAR: begin
                // empty every key, zero the pointers on the way
                key_we    = 1'b1;
                key_waddr = r_clr;
                if (r_clr < SLOT_AW'(SHARDS)) begin
                    ptr_we    = 1'b1;
                    ptr_waddr = r_clr[SHARD_AW-1:0];
                    ptr_wdata = '0;
                end
                if (r_clr == SLOT_AW'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_func    = i_in.func;
                    n_key     = i_in.contact_key;
                    n_layer   = i_in.terrain_layer_involved;
                    n_terrain = i_in.terrain_material_seen;
                    n_ra      = i_in.restitution_a;
                    n_rb      = i_in.restitution_b;
                    n_state   = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_shard = mod_rem;
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                n_base    = SLOT_AW'(32'(r_shard) * ENTRIES);
                n_rd_idx  = '0;
                n_rd_done = 1'b0;
                n_chk_v   = 1'b0;
                n_res     = '0;
                priority if (r_func == FUNC_REMOVE) begin
                    n_state = key_zero ? ST_RESULT : ST_SEARCH;
                end else if ((r_func == FUNC_ADD || r_func == FUNC_PERSIST) && r_layer) begin
                    if (!key_zero) begin
                        n_state = ST_SEARCH;
                    end else if (add_terrain) begin
                        // empty key: combine but never store
                        n_state = ST_INSERT;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end else begin
                    // no terrain layer or unused operation
                    n_state = ST_RESULT;
                end
            end
            ST_SEARCH: begin
                // issue side
                n_chk_v   = !r_rd_done;
                n_chk_idx = r_rd_idx;
                if (!r_rd_done) begin
                    if (r_rd_idx == PTR_W'(ENTRIES - 1)) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
                // compare side, first match wins
                priority if (r_chk_v && key_rdata == r_key) begin
                    n_slot  = r_base + SLOT_AW'(r_chk_idx);
                    n_state = ST_HIT;
                end else if (r_chk_v && r_chk_idx == PTR_W'(ENTRIES - 1)) begin
                    n_state = add_terrain ? ST_INSERT : ST_RESULT;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_HIT: begin
                if (r_func == FUNC_REMOVE) begin
                    key_we    = 1'b1;
                    key_waddr = r_slot;
                    key_wdata = '0;
                    n_res     = '{settings_valid: 1'b0, cache_hit: 1'b1,
                                  friction: '0, restitution: '0};
                    n_state   = ST_RESULT;
                end else begin
                    // stored values arrive next cycle
                    n_state = ST_VREAD;
                end
            end
            ST_VREAD: begin
                n_res   = '{settings_valid: 1'b1, cache_hit: 1'b1,
                            friction: val_rdata[2*VAL_W-1:VAL_W],
                            restitution: val_rdata[VAL_W-1:0]};
                n_state = ST_RESULT;
            end
            ST_INSERT: begin
                if (sqrt_done) begin
                    n_res = '{settings_valid: 1'b1, cache_hit: 1'b0,
                              friction: sqrt_root, restitution: max_r};
                    if (!key_zero) begin
                        // FIFO slot of the shard, then advance the pointer
                        key_we    = 1'b1;
                        key_waddr = r_base + SLOT_AW'(ptr_rdata);
                        key_wdata = r_key;
                        val_we    = 1'b1;
                        ptr_we    = 1'b1;
                    end
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_v || o_out.ready) begin
                    n_out   = r_res;
                    n_out_v = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_out_v   <= 1'b0;
            r_rd_done <= 1'b0;
            r_chk_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_out_v   <= n_out_v;
            r_rd_done <= n_rd_done;
            r_chk_v   <= n_chk_v;
        end
        r_func    <= n_func;
        r_key     <= n_key;
        r_layer   <= n_layer;
        r_terrain <= n_terrain;
        r_ra      <= n_ra;
        r_rb      <= n_rb;
        r_shard   <= n_shard;
        r_base    <= n_base;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_slot    <= n_slot;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_v;
    assign o_out.settings_valid  = r_out.settings_valid;
    assign o_out.cache_hit       = r_out.cache_hit;
    assign o_out.friction_out    = r_out.friction;
    assign o_out.restitution_out = r_out.restitution;
endmodule

>>> sv/sfcmc_ram.sv
// generic simple dual-port ram with registered read
module sfcmc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/sfcmc_keymod.sv
// key modulo shard count: folded sum of key chunks, then a reciprocal multiply
module sfcmc_keymod
    import sfcmc_pkg::*;
#(
    parameter  int SHARDS = DEF_SHARDS,
    localparam int REM_W  = (SHARDS > 1) ? $clog2(SHARDS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_done,
    output logic [REM_W-1:0] o_rem
);
    localparam int CHUNK_W = 16;
    // chunk plus three chunks times a weight below 256
    localparam int FOLD_W  = CHUNK_W + 10;
    localparam int LOG_S   = (SHARDS > 1) ? $clog2(SHARDS) : 0;
    localparam int SH      = FOLD_W + LOG_S;
    localparam int RECIP_W = FOLD_W + 2;
    localparam int PROD_W  = FOLD_W + RECIP_W;

    // weight of each upper key chunk, 2**(16*i) mod SHARDS
    localparam logic [FOLD_W-1:0] WT1 = FOLD_W'((64'd1 << CHUNK_W) % SHARDS);
    localparam logic [FOLD_W-1:0] WT2 = FOLD_W'((64'd1 << (2 * CHUNK_W)) % SHARDS);
    localparam logic [FOLD_W-1:0] WT3 = FOLD_W'((64'd1 << (3 * CHUNK_W)) % SHARDS);
    // ceil(2**SH / SHARDS) gives the exact quotient of any folded value
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SH) + 64'(SHARDS) - 64'd1) / 64'(SHARDS));
    localparam logic [FOLD_W-1:0] DIVISOR = FOLD_W'(SHARDS);

    logic [FOLD_W-1:0] r_fold, n_fold;
    logic [FOLD_W-1:0] r_fold_d;
    logic [FOLD_W-1:0] r_quot, n_quot;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic              r_v1;
    logic              r_v2;
    logic              r_done, n_done;
    logic [PROD_W-1:0] prod;
    logic [FOLD_W-1:0] back;

    always_comb begin
        n_fold = FOLD_W'(i_key[CHUNK_W-1:0])
               + FOLD_W'(i_key[2*CHUNK_W-1:CHUNK_W]) * WT1
               + FOLD_W'(i_key[3*CHUNK_W-1:2*CHUNK_W]) * WT2
               + FOLD_W'(i_key[4*CHUNK_W-1:3*CHUNK_W]) * WT3;
        prod   = PROD_W'(r_fold) * PROD_W'(RECIP);
        n_quot = FOLD_W'(prod >> SH);
        back   = r_quot * DIVISOR;
        n_rem  = REM_W'(r_fold_d - back);
        n_done = r_done;
        if (i_start) begin
            n_done = 1'b0;
        end else if (r_v2) begin
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= n_done;
        end
        if (i_start) begin
            r_fold <= n_fold;
        end
        if (r_v1) begin
            r_fold_d <= r_fold;
            r_quot   <= n_quot;
        end
        if (r_v2) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

>>> sv/sfcmc_isqrt.sv
// geometric mean of two frictions: product, then bitwise integer square root
module sfcmc_isqrt
    import sfcmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_done,
    output logic [VAL_W-1:0] o_root
);
    localparam int PW = 2 * VAL_W;

    logic [PW-1:0] r_v, n_v;
    logic [PW-1:0] r_root, n_root;
    logic [PW-1:0] r_bit, n_bit;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [PW-1:0] sum;

    always_comb begin
        sum    = r_root + r_bit;
        n_v    = r_v;
        n_root = r_root;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_v    = PW'(i_a) * PW'(i_b);
            n_root = '0;
            n_bit  = PW'(1) << (PW - 2);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            if (r_v >= sum) begin
                n_v    = r_v - sum;
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v    <= n_v;
        r_root <= n_root;
        r_bit  <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_root[VAL_W-1:0];
endmodule

>>> sv/sfcmc_checker.sv
// port-level checks of the contact-material cache and their bind
module sfcmc_checker
    import sfcmc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_settings_valid,
    input logic             i_cache_hit,
    input logic [VAL_W-1:0] i_friction_out,
    input logic [VAL_W-1:0] i_restitution_out
);
    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] r_cnt, n_cnt;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // items taken in but not yet delivered
    always_comb begin
        n_cnt = r_cnt;
        if (in_xfer && !out_xfer) begin
            n_cnt = r_cnt + 2'd1;
        end else if (out_xfer && !in_xfer) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_settings_valid, i_cache_hit, i_friction_out, i_restitution_out}))
        else $error("stalled result changed");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_settings_valid |-> i_friction_out == '0 && i_restitution_out == '0)
        else $error("values given without settings_valid");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("ready or valid right after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 2'd0)
        else $error("result without a pending item");

    a_two_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_cnt != 2'd2)
        else $error("item taken while one waits and one is worked on");
endmodule

bind sharded_fifo_contact_material_cache sfcmc_checker u_sfcmc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_settings_valid  (o_out.settings_valid),
    .i_cache_hit       (o_out.cache_hit),
    .i_friction_out    (o_out.friction_out),
    .i_restitution_out (o_out.restitution_out)
);

>>> verif/sharded_fifo_contact_material_cache_test.sv
// self-checking testbench for the sharded contact-material cache
`timescale 1ns / 1ps

module sharded_fifo_contact_material_cache_test;
    import sfcmc_pkg::*;

    // block is built with its default geometry
    localparam int SHARD_COUNT = DEF_SHARDS;
    localparam int NUM_ENTRIES = DEF_ENTRIES;
    localparam int NUM_SLOTS   = SHARD_COUNT * NUM_ENTRIES;

    // the fourth operation code has no name in the package
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // shard that most pool keys land in, so its fifo pointer wraps
    localparam int CROWDED_SHARD = 10;
    localparam int CROWDED_KEYS  = 80;
    localparam int SPREAD_KEYS   = 60;

    // items per random phase, not counting ones the block ignores
    localparam int PHASE_ITEMS = 260;

    // long receiver hold-off that backs the block up into its input
    localparam int LONG_HOLD = 600;

    // margin for the tail of the slowest item
    localparam int SETTLE_CYCLES = 150;

    // quiet-cycle limit: clearing pass plus the long hold
    // plus a few slow items under heavy receiver stalls, several times over
    localparam int QUIET_LIMIT = 8000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic              layer;
        logic              terrain;
        logic [VAL_W-1:0]  fa;
        logic [VAL_W-1:0]  ra;
        logic [VAL_W-1:0]  fb;
        logic [VAL_W-1:0]  rb;
    } t_contact_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sfcmc_in_if  in_ch ();
    sfcmc_out_if out_ch ();

    sharded_fifo_contact_material_cache DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: a private copy of the cache contents
    // ---------------------------------------------------------------
    logic [KEY_W-1:0] cached_key      [NUM_SLOTS];
    logic [VAL_W-1:0] cached_friction [NUM_SLOTS];
    logic [VAL_W-1:0] cached_restit   [NUM_SLOTS];
    int unsigned      fifo_ptr        [SHARD_COUNT];

    // stimulus and expectations
    t_contact_item    contact_queue [$];
    t_result          material_q    [$];
    logic [KEY_W-1:0] key_pool      [$];

    int  fail_count    = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    bit  offer_live    = 1'b0;

    // inputs known from time zero
    initial begin
        in_ch.valid                  = 1'b0;
        in_ch.func                   = '0;
        in_ch.contact_key            = '0;
        in_ch.terrain_layer_involved = 1'b0;
        in_ch.terrain_material_seen  = 1'b0;
        in_ch.friction_a             = '0;
        in_ch.restitution_a          = '0;
        in_ch.friction_b             = '0;
        in_ch.restitution_b          = '0;
        out_ch.ready                 = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            cached_key[s]      = '0;
            cached_friction[s] = '0;
            cached_restit[s]   = '0;
        end
        for (int h = 0; h < SHARD_COUNT; h++) begin
            fifo_ptr[h] = 0;
        end
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // floor of the square root, bit by bit from the top
    function automatic logic [VAL_W-1:0] floor_sqrt(input logic [31:0] v);
        logic [VAL_W-1:0] r;
        r = '0;
        for (int b = VAL_W - 1; b >= 0; b--) begin
            r[b] = 1'b1;
            if (32'(r) * 32'(r) > v) begin
                r[b] = 1'b0;
            end
        end
        return r;
    endfunction

    // expected outcome of one contact, updating the private cache copy
    function automatic t_result predict_material(input t_contact_item it);
        int unsigned shard;
        int unsigned base;
        int unsigned slot;
        int          found;
        t_result     r;
        r     = '0;
        shard = int'(it.key % SHARD_COUNT);
        base  = shard * NUM_ENTRIES;
        found = -1;
        // empty key never matches; first matching slot wins
        if (it.key != '0) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (found < 0 && cached_key[base + i] == it.key) begin
                    found = base + i;
                end
            end
        end
        if (it.func == FUNC_REMOVE) begin
            // terrain flags play no part in a remove
            if (found >= 0) begin
                cached_key[found] = '0;
                r.cache_hit       = 1'b1;
            end
        end else if ((it.func == FUNC_ADD || it.func == FUNC_PERSIST) && it.layer) begin
            if (found >= 0) begin
                r.settings_valid = 1'b1;
                r.cache_hit      = 1'b1;
                r.friction       = cached_friction[found];
                r.restitution    = cached_restit[found];
            end else if (it.func == FUNC_ADD && it.terrain) begin
                r.settings_valid = 1'b1;
                r.friction       = floor_sqrt(32'(it.fa) * 32'(it.fb));
                r.restitution    = (it.ra > it.rb) ? it.ra : it.rb;
                // the empty key gets values back but is never stored
                if (it.key != '0) begin
                    slot                  = base + fifo_ptr[shard];
                    cached_key[slot]      = it.key;
                    cached_friction[slot] = r.friction;
                    cached_restit[slot]   = r.restitution;
                    fifo_ptr[shard]       = (fifo_ptr[shard] + 1) % NUM_ENTRIES;
                end
            end
        end
        return r;
    endfunction

    function automatic t_contact_item make_item(
        input logic [FUNC_W-1:0] func,
        input logic [KEY_W-1:0]  key,
        input logic              layer,
        input logic              terrain,
        input logic [VAL_W-1:0]  fa,
        input logic [VAL_W-1:0]  ra,
        input logic [VAL_W-1:0]  fb,
        input logic [VAL_W-1:0]  rb
    );
        t_contact_item it;
        it.func    = func;
        it.key     = key;
        it.layer   = layer;
        it.terrain = terrain;
        it.fa      = fa;
        it.ra      = ra;
        it.fb      = fb;
        it.rb      = rb;
        return it;
    endfunction

    // material value with the extremes well represented
    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return '0;
        end else if (roll < 16) begin
            return '1;
        end
        return VAL_W'($urandom);
    endfunction

    function automatic t_contact_item random_contact();
        t_contact_item it;
        int unsigned   roll;
        roll = $urandom_range(99);
        if (roll < 50) begin
            it.func = FUNC_ADD;
        end else if (roll < 78) begin
            it.func = FUNC_PERSIST;
        end else if (roll < 96) begin
            it.func = FUNC_REMOVE;
        end else begin
            it.func = FUNC_UNUSED;
        end
        // mostly recurring keys so hits, evictions and removes happen
        roll = $urandom_range(99);
        if (roll < 85) begin
            it.key = key_pool[$urandom_range(key_pool.size() - 1)];
        end else if (roll < 97) begin
            it.key = {$urandom, $urandom};
        end else begin
            it.key = '0;
        end
        it.layer   = ($urandom_range(99) < 90);
        it.terrain = ($urandom_range(99) < 85);
        it.fa      = pick_value();
        it.ra      = pick_value();
        it.fb      = pick_value();
        it.rb      = pick_value();
        return it;
    endfunction

    // queue random contacts; items the block ignores do not count
    task automatic queue_random(input int count);
        t_contact_item it;
        int            useful;
        useful = 0;
        while (useful < count) begin
            it = random_contact();
            contact_queue.push_back(it);
            if (it.func == FUNC_REMOVE ||
                ((it.func == FUNC_ADD || it.func == FUNC_PERSIST) && it.layer)) begin
                useful++;
            end
        end
    endtask

    task automatic drain_all();
        while (contact_queue.size() != 0 || material_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------
    // driver: offers the head of the contact queue at the falling edge
    // and holds it until the transfer happens
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!offer_live) begin
            if (contact_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.func                   <= contact_queue[0].func;
                in_ch.contact_key            <= contact_queue[0].key;
                in_ch.terrain_layer_involved <= contact_queue[0].layer;
                in_ch.terrain_material_seen  <= contact_queue[0].terrain;
                in_ch.friction_a             <= contact_queue[0].fa;
                in_ch.restitution_a          <= contact_queue[0].ra;
                in_ch.friction_b             <= contact_queue[0].fb;
                in_ch.restitution_b          <= contact_queue[0].rb;
                in_ch.valid                  <= 1'b1;
                offer_live = 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // input transfer: predict at the rising edge it happens on
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            material_q.push_back(predict_material(contact_queue.pop_front()));
            offer_live = 1'b0;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitor: each result transfer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.settings_valid = out_ch.settings_valid;
            got.cache_hit      = out_ch.cache_hit;
            got.friction       = out_ch.friction_out;
            got.restitution    = out_ch.restitution_out;
            if (material_q.size() == 0) begin
                note_failure($sformatf("unexpected result valid=%0b hit=%0b f=%h r=%h",
                    got.settings_valid, got.cache_hit, got.friction, got.restitution));
            end else begin
                want = material_q.pop_front();
                if (got.settings_valid !== want.settings_valid ||
                    got.cache_hit      !== want.cache_hit ||
                    got.friction       !== want.friction ||
                    got.restitution    !== want.restitution) begin
                    note_failure($sformatf(
                        "result mismatch: expected valid=%0b hit=%0b f=%h r=%h, got valid=%0b hit=%0b f=%h r=%h",
                        want.settings_valid, want.cache_hit, want.friction, want.restitution,
                        got.settings_valid, got.cache_hit, got.friction, got.restitution));
                end
            end
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("sharded_fifo_contact_material_cache_test: FAIL");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] k_a;
        logic [KEY_W-1:0] k_b;
        logic [KEY_W-1:0] k_c;

        // key pool: a crowded shard to force fifo wrap, the rest spread out
        for (int i = 0; i < CROWDED_KEYS + SPREAD_KEYS; i++) begin
            k = {$urandom, $urandom};
            if (i < CROWDED_KEYS) begin
                k = k - (k % SHARD_COUNT) + CROWDED_SHARD;
            end
            if (k == '0) begin
                k = CROWDED_SHARD;
            end
            key_pool.push_back(k);
        end
        k_a = key_pool[0];
        k_b = key_pool[CROWDED_KEYS];
        k_c = key_pool[CROWDED_KEYS + 1];

        // first phase: sender idles a little, receiver a lot
        send_idle_pct = 21;
        recv_idle_pct = 70;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        // add miss with terrain: largest friction product, restitution max
        contact_queue.push_back(make_item(FUNC_ADD, k_a, 1, 1, '1, '0, '1, '1));
        // add hit, then persist hit on the same key
        contact_queue.push_back(make_item(FUNC_ADD, k_a, 1, 1, 16'h1234, 0, 16'h0001, 0));
        contact_queue.push_back(make_item(FUNC_PERSIST, k_a, 1, 0, 0, 0, 0, 0));
        // persist miss
        contact_queue.push_back(make_item(FUNC_PERSIST, k_b, 1, 1, '1, '1, '1, '1));
        // add miss with no terrain material
        contact_queue.push_back(make_item(FUNC_ADD, k_b, 1, 0, '1, '1, '1, '1));
        // no terrain layer, on add and on persist of a stored key
        contact_queue.push_back(make_item(FUNC_ADD, k_c, 0, 1, '1, '1, '1, '1));
        contact_queue.push_back(make_item(FUNC_PERSIST, k_a, 0, 1, 0, 0, 0, 0));
        // empty key: add computes but stores nothing, persist and remove miss
        contact_queue.push_back(make_item(FUNC_ADD, '0, 1, 1, 16'h4000, 16'h0800,
                                          16'h1000, 16'h0900));
        contact_queue.push_back(make_item(FUNC_PERSIST, '0, 1, 1, 0, 0, 0, 0));
        contact_queue.push_back(make_item(FUNC_REMOVE, '0, 1, 1, 0, 0, 0, 0));
        // remove hit, then a second remove and a persist that miss
        contact_queue.push_back(make_item(FUNC_REMOVE, k_a, 1, 1, 0, 0, 0, 0));
        contact_queue.push_back(make_item(FUNC_REMOVE, k_a, 1, 1, 0, 0, 0, 0));
        contact_queue.push_back(make_item(FUNC_PERSIST, k_a, 1, 1, 0, 0, 0, 0));
        // unused operation code
        contact_queue.push_back(make_item(FUNC_UNUSED, k_a, 1, 1, '1, '1, '1, '1));
        // zero friction side, restitution from the first side
        contact_queue.push_back(make_item(FUNC_ADD, k_c, 1, 1, 0, '1, '1, 0));
        // all-ones key: insert, persist hit, remove with flags clear, persist miss
        contact_queue.push_back(make_item(FUNC_ADD, '1, 1, 1, 16'h2000, 16'h0001,
                                          16'h3000, 16'h7fff));
        contact_queue.push_back(make_item(FUNC_PERSIST, '1, 1, 0, 0, 0, 0, 0));
        contact_queue.push_back(make_item(FUNC_REMOVE, '1, 0, 0, 0, 0, 0, 0));
        contact_queue.push_back(make_item(FUNC_PERSIST, '1, 1, 1, 0, 0, 0, 0));
        // re-add of a removed key lands at the next fifo slot
        contact_queue.push_back(make_item(FUNC_ADD, k_a, 1, 1, 16'h1000, 16'h0100,
                                          16'h1000, 16'h0200));
        contact_queue.push_back(make_item(FUNC_ADD, k_a, 1, 1, 0, 0, 0, 0));

        queue_random(PHASE_ITEMS);
        drain_all();

        // second phase: idling the other way round
        send_idle_pct = 70;
        recv_idle_pct = 21;
        queue_random(PHASE_ITEMS);
        drain_all();

        // third phase: no idling, with one long receiver hold-off while
        // the sender keeps offering, so the block backs up into its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(PHASE_ITEMS);
        hold_requests++;
        drain_all();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (material_q.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", material_q.size()));
        end

        if (fail_count == 0) begin
            $display("sharded_fifo_contact_material_cache_test: PASS");
        end else begin
            $display("sharded_fifo_contact_material_cache_test: FAIL");
        end
        $finish;
    end

endmodule
